// File: rtl/core/uer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// uer_pkg
// Types and constants shared by the echo ranger and its channel interfaces.
// -----------------------------------------------------------------------------
package uer_pkg;

	// field widths
	localparam int OPCODE_W  = 2;
	localparam int CHAN_W    = 1;
	localparam int TIME_W    = 16;
	localparam int DIST_W    = 14;
	localparam int STOPDIST_W = 12;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_START   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ARM     = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_CAPTURE = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_STOPDIST = 1'b1;

	localparam logic [TIME_W-1:0]     PERIOD_RESET   = 16'd19500;
	localparam logic [STOPDIST_W-1:0] STOPDIST_RESET = 12'd300;

	// capture phase of one channel
	typedef enum logic [3:0] {
		PH_NORESULT  = 4'b0001,
		PH_WAIT_HIGH = 4'b0010,
		PH_WAIT_LOW  = 4'b0100,
		PH_COMPLETE  = 4'b1000
	} phase_t;

	// distance arithmetic: mm = 171 * width / 1000
	localparam logic [7:0]        MM_PER_MS_HALF = 8'd171;
	localparam logic [TIME_W-1:0] TIMEOUT_WIDTH  = 16'd2000;
	localparam logic [DIST_W-1:0] MIN_REPORTED   = 14'd20;
	localparam logic [DIST_W-1:0] MAX_REPORTED   = 14'd4000;

	// product 171 * width fits 24 bits; /1000 as multiply by ceil(2^34/1000),
	// exact for every product below 2^24
	localparam int PROD_W      = 24;
	localparam int RECIP_W     = 25;
	localparam int RECIP_SHIFT = 34;
	localparam logic [RECIP_W-1:0] RECIP = 25'd17179870;

endpackage
`default_nettype wire

// File: rtl/core/uer_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// uer_cmd_if
// Command word channel of the echo ranger: start, arm and capture events.
// -----------------------------------------------------------------------------
interface uer_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [uer_pkg::OPCODE_W-1:0]  opcode;
	logic [uer_pkg::CHAN_W-1:0]    channel;
	logic [uer_pkg::TIME_W-1:0]    capture_time;

	modport source (output valid, opcode, channel, capture_time, input ready);
	modport sink   (input valid, opcode, channel, capture_time, output ready);
endinterface
`default_nettype wire

// File: rtl/core/uer_rpt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// uer_rpt_if
// Report word channel of the echo ranger: one status word per command word.
// -----------------------------------------------------------------------------
interface uer_rpt_if;
	logic                        valid;
	logic                        ready;
	logic [uer_pkg::CHAN_W-1:0]  report_channel;
	logic [uer_pkg::DIST_W-1:0]  distance_mm;
	logic                        reading_new;
	logic                        stop_active;
	logic                        trigger_level;

	modport source (output valid, report_channel, distance_mm, reading_new, stop_active,
		trigger_level, input ready);
	modport sink   (input valid, report_channel, distance_mm, reading_new, stop_active,
		trigger_level, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Multi-channel ultrasonic echo ranger: trigger control, echo width capture,
// distance conversion and per-channel stop flag.
// -----------------------------------------------------------------------------
// Takes one command word per cycle while the command side is not stalled, and
// returns one report word per command, in order. A word passes through five
// register stages: input register, channel state update with echo width,
// multiply by 171, reciprocal multiply for the divide by 1000, and the report
// register where the stop flag is decided. Each stage holds its word
// independently, so bubbles close up and commands keep coming in while a
// report waits, until all five stages are full.
module ultrasonic_echo_ranger #(
	parameter int CHANNELS = 2
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [uer_pkg::CFG_DATA_W-1:0]   cfg_data,
	uer_cmd_if.sink                               cmd,
	uer_rpt_if.source                             rpt
);

	localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int TIME_W   = uer_pkg::TIME_W;
	localparam int DIST_W   = uer_pkg::DIST_W;
	localparam int PROD_W   = uer_pkg::PROD_W;
	localparam int SCALED_W = uer_pkg::PROD_W + uer_pkg::RECIP_W;

	// configuration
	logic [TIME_W-1:0]              period_q;
	logic [uer_pkg::STOPDIST_W-1:0] stop_dist_q;

	// channel state
	uer_pkg::phase_t   phase_q [CHANNELS];
	logic [TIME_W-1:0] rise_q  [CHANNELS];
	logic [TIME_W-1:0] width_q [CHANNELS];
	logic              stop_flag_q [CHANNELS];
	logic              trig_q;

	// pipeline
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	logic [uer_pkg::OPCODE_W-1:0] opcode_s1;
	logic [uer_pkg::CHAN_W-1:0]   ch_s1, ch_s2, ch_s3, ch_s4, ch_s5;
	logic [TIME_W-1:0]            cap_s1;
	logic                         chv_s2, chv_s3, chv_s4;
	logic                         fresh_s2, fresh_s3, fresh_s4, fresh_s5;
	logic                         trig_s2, trig_s3, trig_s4, trig_s5;
	logic [TIME_W-1:0]            width_s2;
	logic [PROD_W-1:0]            prod_s3;
	logic [DIST_W-1:0]            quot_s4;
	logic [DIST_W-1:0]            dist_s5;
	logic                         stop_s5;

	assign rdy_s5 = !v_s5 || rpt.ready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign cmd.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= cmd.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= uer_pkg::PERIOD_RESET;
			stop_dist_q <= uer_pkg::STOPDIST_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				uer_pkg::REG_PERIOD:   period_q    <= cfg_data[TIME_W-1:0];
				uer_pkg::REG_STOPDIST: stop_dist_q <= cfg_data[uer_pkg::STOPDIST_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (rdy_s1 && cmd.valid) begin
			opcode_s1 <= cmd.opcode;
			ch_s1     <= cmd.channel;
			cap_s1    <= cmd.capture_time;
		end
	end

	// stage 1 -> 2: channel state update
	logic              adv_s1;
	logic              chv_d;
	logic [IDX_W-1:0]  idx_d;
	logic [TIME_W-1:0] diff_d;
	logic [TIME_W-1:0] echo_d;
	logic              fresh_d;
	logic              trig_d;
	uer_pkg::phase_t   phase_d [CHANNELS];
	logic [TIME_W-1:0] rise_d  [CHANNELS];
	logic [TIME_W-1:0] width_d [CHANNELS];

	assign adv_s1 = v_s1 && rdy_s2;
	assign chv_d  = 32'(ch_s1) < CHANNELS;
	assign idx_d  = chv_d ? IDX_W'(ch_s1) : '0;
	assign diff_d = cap_s1 - rise_q[idx_d];
	// capture wrapped past the period: add the period back
	assign echo_d = (cap_s1 >= rise_q[idx_d]) ? diff_d : diff_d + period_q;

	always_comb begin
		phase_d = phase_q;
		rise_d  = rise_q;
		width_d = width_q;
		trig_d  = trig_q;
		fresh_d = 1'b0;
		unique case (opcode_s1)
			uer_pkg::OP_START: begin
				for (int i = 0; i < CHANNELS; i++) begin
					if (phase_q[i] != uer_pkg::PH_COMPLETE) width_d[i] = uer_pkg::TIMEOUT_WIDTH;
				end
				trig_d = 1'b1;
			end
			uer_pkg::OP_ARM: begin
				for (int i = 0; i < CHANNELS; i++) begin
					phase_d[i] = uer_pkg::PH_WAIT_HIGH;
				end
				trig_d = 1'b0;
			end
			uer_pkg::OP_CAPTURE: begin
				if (chv_d) begin
					if (phase_q[idx_d] == uer_pkg::PH_WAIT_HIGH) begin
						rise_d[idx_d]  = cap_s1;
						phase_d[idx_d] = uer_pkg::PH_WAIT_LOW;
					end else if (phase_q[idx_d] == uer_pkg::PH_WAIT_LOW) begin
						width_d[idx_d] = echo_d;
						phase_d[idx_d] = uer_pkg::PH_COMPLETE;
						fresh_d        = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				phase_q[i] <= uer_pkg::PH_NORESULT;
				rise_q[i]  <= '0;
				width_q[i] <= '0;
			end
			trig_q <= 1'b0;
		end else if (adv_s1) begin
			phase_q <= phase_d;
			rise_q  <= rise_d;
			width_q <= width_d;
			trig_q  <= trig_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ch_s2    <= ch_s1;
			chv_s2   <= chv_d;
			fresh_s2 <= fresh_d;
			trig_s2  <= trig_d;
			width_s2 <= width_d[idx_d];
		end
	end

	// stage 2 -> 3: 171 * width
	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			ch_s3    <= ch_s2;
			chv_s3   <= chv_s2;
			fresh_s3 <= fresh_s2;
			trig_s3  <= trig_s2;
			prod_s3  <= PROD_W'(width_s2) * PROD_W'(uer_pkg::MM_PER_MS_HALF);
		end
	end

	// stage 3 -> 4: divide by 1000 through the reciprocal
	logic [SCALED_W-1:0] scaled_d;
	assign scaled_d = SCALED_W'(prod_s3) * SCALED_W'(uer_pkg::RECIP);

	always_ff @(posedge clk) begin
		if (v_s3 && rdy_s4) begin
			ch_s4    <= ch_s3;
			chv_s4   <= chv_s3;
			fresh_s4 <= fresh_s3;
			trig_s4  <= trig_s3;
			quot_s4  <= scaled_d[uer_pkg::RECIP_SHIFT +: DIST_W];
		end
	end

	// stage 4 -> 5: reported distance and stop flag
	logic              adv_s4;
	logic [IDX_W-1:0]  idx_s4;
	logic [DIST_W-1:0] dist_d;
	logic              below_d;
	logic              stop_d;

	assign adv_s4  = v_s4 && rdy_s5;
	assign idx_s4  = chv_s4 ? IDX_W'(ch_s4) : '0;
	assign dist_d  = (chv_s4 && quot_s4 > uer_pkg::MIN_REPORTED) ? quot_s4
		: uer_pkg::MAX_REPORTED;
	assign below_d = dist_d < DIST_W'(stop_dist_q);
	// every older word has already written its flag by the time this one gets here
	assign stop_d  = !chv_s4 ? 1'b0 : (fresh_s4 ? below_d : stop_flag_q[idx_s4]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				stop_flag_q[i] <= 1'b0;
			end
		end else if (adv_s4 && fresh_s4) begin
			stop_flag_q[idx_s4] <= below_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			ch_s5    <= ch_s4;
			fresh_s5 <= fresh_s4;
			trig_s5  <= trig_s4;
			dist_s5  <= dist_d;
			stop_s5  <= stop_d;
		end
	end

	assign rpt.valid          = v_s5;
	assign rpt.report_channel = ch_s5;
	assign rpt.distance_mm    = dist_s5;
	assign rpt.reading_new    = fresh_s5;
	assign rpt.stop_active    = stop_s5;
	assign rpt.trigger_level  = trig_s5;

	// a new reading carries the flag that its own distance decides
	a_fresh_stop: assert property (@(posedge clk) disable iff (!arst_n)
		rpt.valid && rpt.reading_new |->
			rpt.stop_active == (rpt.distance_mm < DIST_W'(stop_dist_q)))
		else $error("stop flag disagrees with fresh distance");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		rpt.valid |-> (rpt.distance_mm == uer_pkg::MAX_REPORTED ||
			(rpt.distance_mm > uer_pkg::MIN_REPORTED && rpt.distance_mm <= 14'd11206)))
		else $error("reported distance out of range");

	// the command side only stalls when every stage holds a word
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5))
		else $error("command stalled with a free stage");

	a_bad_channel: assert property (@(posedge clk) disable iff (!arst_n)
		rpt.valid && (32'(rpt.report_channel) >= CHANNELS) |->
			(rpt.distance_mm == uer_pkg::MAX_REPORTED && !rpt.reading_new && !rpt.stop_active))
		else $error("report for absent channel not blank");

endmodule
`default_nettype wire

// File: test/tb_ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger
// Self-checking bench for the echo ranger. Command words go in through a
// queue-fed driver. Each accepted word is run through a behavioural ranging
// model here, which predicts its report word. A monitor checks each report
// word against the oldest prediction. The run has a short directed section,
// then random measurement sequences mixed with noise under several register
// settings. Both sides stall at random, and there is one long report stall.
// -----------------------------------------------------------------------------
module tb_ultrasonic_echo_ranger;

	localparam int CHANNELS   = 2;
	localparam int OPCODE_W   = uer_pkg::OPCODE_W;
	localparam int CHAN_W     = uer_pkg::CHAN_W;
	localparam int TIME_W     = uer_pkg::TIME_W;
	localparam int DIST_W     = uer_pkg::DIST_W;
	localparam int STOPDIST_W = uer_pkg::STOPDIST_W;
	localparam int CFG_IDX_W  = uer_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = uer_pkg::CFG_DATA_W;
	localparam logic [OPCODE_W-1:0] OP_STATUS = 2'd3;	// unused code, reports status only

	localparam int SPEED_HALF  = 171;
	localparam int MM_DIV      = 1000;
	localparam int MIN_MM      = 20;
	localparam int NO_ECHO_MM  = 4000;
	localparam int ECHO_TMO_US = 2000;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [CHAN_W-1:0]   channel;
		logic [TIME_W-1:0]   capture_time;
	} cmd_word_t;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [DIST_W-1:0] distance_mm;
		logic              reading_new;
		logic              stop_active;
		logic              trigger_level;
	} rpt_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	uer_cmd_if cmd_ch ();
	uer_rpt_if rpt_ch ();

	ultrasonic_echo_ranger #(
		.CHANNELS(CHANNELS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd_ch),
		.rpt(rpt_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ranging model state and register copies
	uer_pkg::phase_t     ch_phase [CHANNELS];
	logic [TIME_W-1:0]   ch_rise  [CHANNELS];
	logic [TIME_W-1:0]   ch_width [CHANNELS];
	logic                ch_stop  [CHANNELS];
	logic                trig_high;
	logic [TIME_W-1:0]     cfg_period;
	logic [STOPDIST_W-1:0] cfg_stop_mm;

	cmd_word_t pending[$];
	rpt_word_t reports_due[$];
	int  queued;
	int  errors;
	int  send_gap;
	int  recv_gap;
	bit  hold_on;
	bit  gaps_on;
	bit  quiet_tail;

	function automatic logic [DIST_W-1:0] mm_of_width(logic [TIME_W-1:0] w);
		int mm;
		mm = (SPEED_HALF * int'(w)) / MM_DIV;
		return (mm > MIN_MM) ? DIST_W'(mm) : DIST_W'(NO_ECHO_MM);
	endfunction

	function automatic rpt_word_t range_step(cmd_word_t c);
		rpt_word_t r;
		logic [31:0] w;
		r = '0;
		case (c.opcode)
			uer_pkg::OP_START: begin
				for (int i = 0; i < CHANNELS; i++)
					if (ch_phase[i] != uer_pkg::PH_COMPLETE)
						ch_width[i] = TIME_W'(ECHO_TMO_US);
				trig_high = 1'b1;
			end
			uer_pkg::OP_ARM: begin
				for (int i = 0; i < CHANNELS; i++)
					ch_phase[i] = uer_pkg::PH_WAIT_HIGH;
				trig_high = 1'b0;
			end
			uer_pkg::OP_CAPTURE: begin
				if (ch_phase[c.channel] == uer_pkg::PH_WAIT_HIGH) begin
					ch_rise[c.channel] = c.capture_time;
					ch_phase[c.channel] = uer_pkg::PH_WAIT_LOW;
				end else if (ch_phase[c.channel] == uer_pkg::PH_WAIT_LOW) begin
					// one conditional add of the period, not a true modulo
					if (c.capture_time >= ch_rise[c.channel])
						w = 32'(c.capture_time) - 32'(ch_rise[c.channel]);
					else
						w = 32'(c.capture_time) + 32'(cfg_period) - 32'(ch_rise[c.channel]);
					ch_width[c.channel] = w[TIME_W-1:0];
					ch_phase[c.channel] = uer_pkg::PH_COMPLETE;
					r.reading_new = 1'b1;
					ch_stop[c.channel] =
						int'(mm_of_width(ch_width[c.channel])) < int'(cfg_stop_mm);
				end
			end
			default: ;
		endcase
		r.channel       = c.channel;
		r.distance_mm   = mm_of_width(ch_width[c.channel]);
		r.stop_active   = ch_stop[c.channel];
		r.trigger_level = trig_high;
		return r;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		if (errors < 100)
			$display("MISMATCH %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	task automatic push_cmd(logic [OPCODE_W-1:0] op, logic [CHAN_W-1:0] ch,
		logic [TIME_W-1:0] t);
		cmd_word_t c;
		c = '{opcode: op, channel: ch, capture_time: t};
		pending.push_back(c);
		queued++;
	endtask

	// registers change only with the block idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == uer_pkg::REG_PERIOD)
			cfg_period = val;
		else
			cfg_stop_mm = val[STOPDIST_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic settle();
		@(negedge clk);
		while (pending.size() != 0 || cmd_ch.valid || reports_due.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [TIME_W-1:0] rise_pick();
		if ($urandom_range(0, 19) == 0)
			return TIME_W'($urandom_range(0, 65535));
		return TIME_W'($urandom_range(0, int'(cfg_period) - 1));
	endfunction

	// falling edge time: short echoes, echoes near the stop distance, or anything
	function automatic logic [TIME_W-1:0] fall_pick(logic [TIME_W-1:0] rise);
		int w;
		if ($urandom_range(0, 29) == 0)
			return TIME_W'($urandom_range(0, 65535));
		case ($urandom_range(0, 2))
			0: w = $urandom_range(0, 160);
			1: begin
				w = int'(cfg_stop_mm) * MM_DIV / SPEED_HALF + $urandom_range(0, 40) - 20;
				if (w < 0)
					w = 0;
			end
			default: w = $urandom_range(0, 65535);
		endcase
		return TIME_W'((int'(rise) + w) % int'(cfg_period));
	endfunction

	task automatic queue_ranging(int n);
		int target;
		logic first_ch;
		logic [TIME_W-1:0] r0;
		logic [TIME_W-1:0] r1;
		target = queued + n;
		while (queued < target) begin
			if ($urandom_range(0, 99) < 78) begin
				first_ch = 1'($urandom_range(0, 1));
				r0 = rise_pick();
				r1 = rise_pick();
				push_cmd(uer_pkg::OP_START, CHAN_W'($urandom_range(0, 1)),
					TIME_W'($urandom_range(0, 65535)));
				if ($urandom_range(0, 7) == 0)
					push_cmd(OP_STATUS, CHAN_W'($urandom_range(0, 1)),
						TIME_W'($urandom_range(0, 65535)));
				push_cmd(uer_pkg::OP_ARM, CHAN_W'($urandom_range(0, 1)),
					TIME_W'($urandom_range(0, 65535)));
				push_cmd(uer_pkg::OP_CAPTURE, first_ch, r0);
				if ($urandom_range(0, 6) != 0)
					push_cmd(uer_pkg::OP_CAPTURE, !first_ch, r1);
				if ($urandom_range(0, 9) != 0)
					push_cmd(uer_pkg::OP_CAPTURE, first_ch, fall_pick(r0));
				// if the other rise was dropped this one acts as its rise
				push_cmd(uer_pkg::OP_CAPTURE, !first_ch, fall_pick(r1));
				if ($urandom_range(0, 5) == 0)
					push_cmd(uer_pkg::OP_CAPTURE, CHAN_W'($urandom_range(0, 1)),
						TIME_W'($urandom_range(0, 65535)));
				if ($urandom_range(0, 3) == 0)
					push_cmd(OP_STATUS, CHAN_W'($urandom_range(0, 1)),
						TIME_W'($urandom_range(0, 65535)));
			end else begin
				push_cmd(OPCODE_W'($urandom_range(0, 3)), CHAN_W'($urandom_range(0, 1)),
					TIME_W'($urandom_range(0, 65535)));
			end
		end
	endtask

	// command driver
	always @(posedge clk) begin : cmd_drive
		cmd_word_t c;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				c = '{opcode: cmd_ch.opcode, channel: cmd_ch.channel,
					capture_time: cmd_ch.capture_time};
				reports_due.push_back(range_step(c));
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_ch.valid <= 1'b0;
				end else if (pending.size() != 0) begin
					c = pending.pop_front();
					cmd_ch.valid        <= 1'b1;
					cmd_ch.opcode       <= c.opcode;
					cmd_ch.channel      <= c.channel;
					cmd_ch.capture_time <= c.capture_time;
					if (gaps_on && !quiet_tail && $urandom_range(0, 11) == 0)
						send_gap = $urandom_range(1, 18);
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// report monitor
	always @(posedge clk) begin : rpt_check
		rpt_word_t want;
		if (arst_n) begin
			if (rpt_ch.valid && rpt_ch.ready) begin
				if (reports_due.size() == 0) begin
					flag_mismatch("report word with none due, channel",
						rpt_ch.report_channel, 0);
				end else begin
					want = reports_due.pop_front();
					if (rpt_ch.report_channel !== want.channel)
						flag_mismatch("report_channel", rpt_ch.report_channel, want.channel);
					if (rpt_ch.distance_mm !== want.distance_mm)
						flag_mismatch("distance_mm", rpt_ch.distance_mm, want.distance_mm);
					if (rpt_ch.reading_new !== want.reading_new)
						flag_mismatch("reading_new", rpt_ch.reading_new, want.reading_new);
					if (rpt_ch.stop_active !== want.stop_active)
						flag_mismatch("stop_active", rpt_ch.stop_active, want.stop_active);
					if (rpt_ch.trigger_level !== want.trigger_level)
						flag_mismatch("trigger_level", rpt_ch.trigger_level, want.trigger_level);
				end
			end
			if (hold_on) begin
				rpt_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				rpt_ch.ready <= 1'b0;
			end else begin
				rpt_ch.ready <= 1'b1;
				if (gaps_on && !quiet_tail && $urandom_range(0, 9) == 0)
					recv_gap = $urandom_range(1, 18);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = '0;
		cmd_ch.channel = '0;
		cmd_ch.capture_time = '0;
		rpt_ch.ready = 1'b0;
		for (int i = 0; i < CHANNELS; i++) begin
			ch_phase[i] = uer_pkg::PH_NORESULT;
			ch_rise[i]  = '0;
			ch_width[i] = '0;
			ch_stop[i]  = 1'b0;
		end
		trig_high = 1'b0;
		cfg_period = uer_pkg::PERIOD_RESET;
		cfg_stop_mm = uer_pkg::STOPDIST_RESET;
		queued = 0;
		errors = 0;
		send_gap = 0;
		recv_gap = 0;
		hold_on = 1'b0;
		gaps_on = 1'b1;
		quiet_tail = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed words at reset settings
		push_cmd(uer_pkg::OP_CAPTURE, 1'b0, 16'd0);	// capture with no measurement running
		push_cmd(OP_STATUS, 1'b1, 16'hFFFF);
		push_cmd(uer_pkg::OP_START, 1'b0, 16'd0);	// timeout width on both channels
		push_cmd(uer_pkg::OP_ARM, 1'b1, 16'd0);
		push_cmd(uer_pkg::OP_CAPTURE, 1'b0, 16'd100);
		push_cmd(uer_pkg::OP_CAPTURE, 1'b1, 16'd19499);
		push_cmd(uer_pkg::OP_CAPTURE, 1'b0, 16'd100);	// zero width
		push_cmd(uer_pkg::OP_CAPTURE, 1'b1, 16'd50);	// wraps past the period
		push_cmd(uer_pkg::OP_CAPTURE, 1'b0, 16'd7);	// already complete, ignored
		push_cmd(uer_pkg::OP_START, 1'b1, 16'd0);	// complete channels keep their width
		push_cmd(uer_pkg::OP_ARM, 1'b0, 16'd0);
		push_cmd(uer_pkg::OP_CAPTURE, 1'b0, 16'd0);
		push_cmd(uer_pkg::OP_CAPTURE, 1'b0, 16'd1754);	// 299 mm, just under stop distance
		push_cmd(uer_pkg::OP_CAPTURE, 1'b1, 16'd65535);	// rise above the period
		push_cmd(uer_pkg::OP_CAPTURE, 1'b1, 16'd0);
		push_cmd(uer_pkg::OP_ARM, 1'b0, 16'd0);
		push_cmd(uer_pkg::OP_CAPTURE, 1'b0, 16'd1000);
		push_cmd(uer_pkg::OP_CAPTURE, 1'b0, 16'd2755);	// exactly the stop distance
		push_cmd(uer_pkg::OP_CAPTURE, 1'b1, 16'd0);
		push_cmd(uer_pkg::OP_CAPTURE, 1'b1, 16'd65535);	// widest echo, largest distance
		push_cmd(uer_pkg::OP_ARM, 1'b0, 16'd0);
		push_cmd(uer_pkg::OP_START, 1'b1, 16'd0);	// start while both channels wait
		push_cmd(uer_pkg::OP_ARM, 1'b0, 16'd0);
		push_cmd(uer_pkg::OP_CAPTURE, 1'b1, 16'd10);
		push_cmd(uer_pkg::OP_CAPTURE, 1'b1, 16'd127);	// 20 mm, reported as no echo
		settle();

		queue_ranging(300);
		// long report stall, input must back up
		fork
			begin : long_hold
				hold_on = 1'b1;
				repeat (150) @(posedge clk);
				hold_on = 1'b0;
			end
		join_none
		settle();

		write_reg(uer_pkg::REG_PERIOD, 16'hFFFF);
		write_reg(uer_pkg::REG_STOPDIST, 16'd4000);
		queue_ranging(250);
		settle();

		write_reg(uer_pkg::REG_PERIOD, 16'd2);
		write_reg(uer_pkg::REG_STOPDIST, 16'd0);
		gaps_on = 1'b0;
		queue_ranging(120);
		settle();

		gaps_on = 1'b1;
		write_reg(uer_pkg::REG_PERIOD, 16'($urandom_range(2000, 65535)));
		write_reg(uer_pkg::REG_STOPDIST, 16'($urandom_range(0, 4000)));
		queue_ranging(250);
		settle();

		write_reg(uer_pkg::REG_PERIOD, 16'($urandom_range(100, 65535)));
		write_reg(uer_pkg::REG_STOPDIST, 16'($urandom_range(1, 4000)));
		quiet_tail = 1'b1;
		queue_ranging(160);
		settle();

		repeat (10) @(posedge clk);
		if (reports_due.size() != 0)
			flag_mismatch("report words never seen", 0, reports_due.size());
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
